// ===== design/lli_pkg.sv =====
`default_nettype none
package lli_pkg;

  // four divisions run side by side through the cell chain
  localparam int NUM_LANES = 4;

  // lane assignment
  localparam int LANE_CX = 0;
  localparam int LANE_CY = 1;
  localparam int LANE_P1 = 2;
  localparam int LANE_P2 = 3;

endpackage
`default_nettype wire

// ===== design/lli_cell.sv =====
`default_nettype none
module lli_cell #(
  parameter int DW = 67,
  parameter int Q  = 34
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_in,
  input  wire logic [DW-1:0] den_in,
  input  wire logic [DW-1:0] rem_in [lli_pkg::NUM_LANES],
  input  wire logic [Q-1:0]  num_in [lli_pkg::NUM_LANES],
  input  wire logic [Q-1:0]  quo_in [lli_pkg::NUM_LANES],
  output logic               valid_out,
  output logic [DW-1:0]      den_out,
  output logic [DW-1:0]      rem_out [lli_pkg::NUM_LANES],
  output logic [Q-1:0]       num_out [lli_pkg::NUM_LANES],
  output logic [Q-1:0]       quo_out [lli_pkg::NUM_LANES]
);
  import lli_pkg::*;

  logic [DW:0]   trial [NUM_LANES];
  logic [NUM_LANES-1:0] fits;
  logic [DW-1:0] rem_next [NUM_LANES];

  // one restoring division step per lane
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      trial[i] = {rem_in[i], num_in[i][Q-1]};
      fits[i] = trial[i] >= {1'b0, den_in};
      if (fits[i]) begin
        rem_next[i] = DW'(trial[i] - {1'b0, den_in});
      end else begin
        rem_next[i] = DW'(trial[i]);
      end
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  // payload handed to the next cell
  always_ff @(posedge clk) begin
    den_out <= den_in;
    for (int i = 0; i < NUM_LANES; i++) begin
      rem_out[i] <= rem_next[i];
      num_out[i] <= {num_in[i][Q-2:0], 1'b0};
      quo_out[i] <= {quo_in[i][Q-2:0], fits[i]};
    end
  end

endmodule
`default_nettype wire

// ===== design/line_line_intersection_core.sv =====
// the result strobe (done) follows the start transfer edge through the input register,
// 7 front stages, COORD_BITS+2 divider cells and the output register
// throughput: one item per cycle; busy is always low and the receiver cannot stall
// the divider is a chain of cells, one quotient bit per cell, four lanes per cell
// reset clears all valid flags, so no result is pending after reset
`default_nettype none
module line_line_intersection_core #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] line1_start_x,
  input  wire logic signed [COORD_BITS-1:0] line1_start_y,
  input  wire logic signed [COORD_BITS-1:0] line1_end_x,
  input  wire logic signed [COORD_BITS-1:0] line1_end_y,
  input  wire logic signed [COORD_BITS-1:0] line2_start_x,
  input  wire logic signed [COORD_BITS-1:0] line2_start_y,
  input  wire logic signed [COORD_BITS-1:0] line2_end_x,
  input  wire logic signed [COORD_BITS-1:0] line2_end_y,
  output logic                              done,
  output logic                              intersects,
  output logic signed [COORD_BITS-1:0]      cross_x,
  output logic signed [COORD_BITS-1:0]      cross_y,
  output logic signed [COORD_BITS-1:0]      param_one,
  output logic signed [COORD_BITS-1:0]      param_two
);
  import lli_pkg::*;

  localparam int W   = COORD_BITS;
  localparam int DFW = W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int DW  = 2 * W + 3;
  localparam int LB  = W + 2;
  localparam int HW  = DW - LB;
  localparam int NW  = (3 * W + 4 >= 2 * W + 3 + FRAC_BITS) ? 3 * W + 4
                                                             : 2 * W + 3 + FRAC_BITS;
  localparam int Q   = W + 2;
  localparam int SW  = W + 4;

  assign busy = 1'b0;

  logic [7:0] v;

  // stage 0: input registers
  logic signed [W-1:0] ax, ay, bx, by, cx0, cy0, ex, ey;
  // stage 1
  logic signed [DFW-1:0] d1x, d1y, d2x, d2y, sx, sy, e2x1, e2y1;
  logic signed [W-1:0]   cx1, cy1;
  // stage 2
  logic signed [PW-1:0]  pa, pb, pc, pd, pe, pf;
  logic signed [DFW-1:0] e2x2, e2y2;
  logic signed [W-1:0]   cx2, cy2;
  // stage 3
  logic signed [DW-1:0]  den3, n13, n23;
  logic signed [DFW-1:0] e2x3, e2y3;
  logic signed [W-1:0]   cx3, cy3;
  // stage 4
  logic signed [LB+DFW:0]   ppx_lo, ppy_lo;
  logic signed [HW+DFW-1:0] ppx_hi, ppy_hi;
  logic signed [DW-1:0]     den4, n14, n24;
  logic signed [W-1:0]      cx4, cy4;
  // stage 5
  logic signed [NW-1:0] num5 [NUM_LANES];
  logic signed [DW-1:0] den5;
  logic signed [W-1:0]  cx5, cy5;
  // stage 6
  logic [NW-1:0]          mag6 [NUM_LANES];
  logic [NUM_LANES-1:0]   nneg6;
  logic [DW-1:0]          dmag6;
  logic                   dneg6, dzero6;
  logic signed [W-1:0]    cx6, cy6;
  // stage 7
  logic [DW-1:0]          rem7 [NUM_LANES];
  logic [Q-1:0]           numlo7 [NUM_LANES];
  logic [Q-1:0]           quo7 [NUM_LANES];
  logic [DW-1:0]          dmag7;
  logic [NUM_LANES-1:0]   qneg7, ovf7;
  logic                   dzero7;
  logic signed [W-1:0]    cx7, cy7;

  // valid pipeline through the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[6:0], start};
    end
  end

  // front datapath
  always_ff @(posedge clk) begin
    if (start) begin
      ax  <= line1_start_x;
      ay  <= line1_start_y;
      bx  <= line1_end_x;
      by  <= line1_end_y;
      cx0 <= line2_start_x;
      cy0 <= line2_start_y;
      ex  <= line2_end_x;
      ey  <= line2_end_y;
    end
    // differences
    d1x  <= DFW'(ax) - DFW'(bx);
    d1y  <= DFW'(ay) - DFW'(by);
    d2x  <= DFW'(cx0) - DFW'(ex);
    d2y  <= DFW'(cy0) - DFW'(ey);
    sx   <= DFW'(ax) - DFW'(cx0);
    sy   <= DFW'(ay) - DFW'(cy0);
    e2x1 <= DFW'(ex) - DFW'(cx0);
    e2y1 <= DFW'(ey) - DFW'(cy0);
    cx1  <= cx0;
    cy1  <= cy0;
    // cross products
    pa   <= PW'(d1x) * PW'(d2y);
    pb   <= PW'(d1y) * PW'(d2x);
    pc   <= PW'(sx) * PW'(d2y);
    pd   <= PW'(sy) * PW'(d2x);
    pe   <= PW'(d1x) * PW'(sy);
    pf   <= PW'(d1y) * PW'(sx);
    e2x2 <= e2x1;
    e2y2 <= e2y1;
    cx2  <= cx1;
    cy2  <= cy1;
    // denominator and numerators
    den3 <= DW'(pa) - DW'(pb);
    n13  <= DW'(pc) - DW'(pd);
    n23  <= DW'(pf) - DW'(pe);
    e2x3 <= e2x2;
    e2y3 <= e2y2;
    cx3  <= cx2;
    cy3  <= cy2;
    // split product of numerator two with the line two direction
    ppx_lo <= (LB+DFW+1)'($signed({1'b0, n23[LB-1:0]})) * (LB+DFW+1)'(e2x3);
    ppy_lo <= (LB+DFW+1)'($signed({1'b0, n23[LB-1:0]})) * (LB+DFW+1)'(e2y3);
    ppx_hi <= (HW+DFW)'($signed(n23[DW-1:LB])) * (HW+DFW)'(e2x3);
    ppy_hi <= (HW+DFW)'($signed(n23[DW-1:LB])) * (HW+DFW)'(e2y3);
    den4 <= den3;
    n14  <= n13;
    n24  <= n23;
    cx4  <= cx3;
    cy4  <= cy3;
    // dividends
    num5[LANE_CX] <= (NW'(ppx_hi) <<< LB) + NW'(ppx_lo);
    num5[LANE_CY] <= (NW'(ppy_hi) <<< LB) + NW'(ppy_lo);
    num5[LANE_P1] <= NW'(n14) <<< FRAC_BITS;
    num5[LANE_P2] <= NW'(n24) <<< FRAC_BITS;
    den5 <= den4;
    cx5  <= cx4;
    cy5  <= cy4;
    // magnitudes and signs
    for (int i = 0; i < NUM_LANES; i++) begin
      nneg6[i] <= num5[i][NW-1];
      mag6[i]  <= num5[i][NW-1] ? NW'(-num5[i]) : NW'(num5[i]);
    end
    dneg6  <= den5[DW-1];
    dmag6  <= den5[DW-1] ? DW'(-den5) : DW'(den5);
    dzero6 <= den5 == '0;
    cx6    <= cx5;
    cy6    <= cy5;
    // overflow check and divider seed
    for (int i = 0; i < NUM_LANES; i++) begin
      ovf7[i]   <= (mag6[i] >> Q) >= NW'(dmag6);
      rem7[i]   <= DW'(mag6[i] >> Q);
      numlo7[i] <= mag6[i][Q-1:0];
      quo7[i]   <= '0;
      qneg7[i]  <= nneg6[i] ^ dneg6;
    end
    dmag7  <= dmag6;
    dzero7 <= dzero6;
    cx7    <= cx6;
    cy7    <= cy6;
  end

  // divider cell chain
  logic          cv   [Q+1];
  logic [DW-1:0] cden [Q+1];
  logic [DW-1:0] crem [Q+1][NUM_LANES];
  logic [Q-1:0]  cnum [Q+1][NUM_LANES];
  logic [Q-1:0]  cquo [Q+1][NUM_LANES];

  assign cv[0]   = v[7];
  assign cden[0] = dmag7;
  assign crem[0] = rem7;
  assign cnum[0] = numlo7;
  assign cquo[0] = quo7;

  for (genvar k = 0; k < Q; k++) begin : g_cell
    lli_cell #(.DW(DW), .Q(Q)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (cv[k]),
      .den_in   (cden[k]),
      .rem_in   (crem[k]),
      .num_in   (cnum[k]),
      .quo_in   (cquo[k]),
      .valid_out(cv[k+1]),
      .den_out  (cden[k+1]),
      .rem_out  (crem[k+1]),
      .num_out  (cnum[k+1]),
      .quo_out  (cquo[k+1])
    );
  end

  // side data travels alongside the cells
  logic signed [W-1:0]  scx [Q];
  logic signed [W-1:0]  scy [Q];
  logic [NUM_LANES-1:0] sneg [Q];
  logic [NUM_LANES-1:0] sovf [Q];
  logic                 szero [Q];

  always_ff @(posedge clk) begin
    scx[0]   <= cx7;
    scy[0]   <= cy7;
    sneg[0]  <= qneg7;
    sovf[0]  <= ovf7;
    szero[0] <= dzero7;
    for (int k = 1; k < Q; k++) begin
      scx[k]   <= scx[k-1];
      scy[k]   <= scy[k-1];
      sneg[k]  <= sneg[k-1];
      sovf[k]  <= sovf[k-1];
      szero[k] <= szero[k-1];
    end
  end

  // sign, offset, saturation and zeroing of parallel results
  logic signed [Q:0]    qs  [NUM_LANES];
  logic signed [SW-1:0] sum [NUM_LANES];
  logic [W-1:0]         res [NUM_LANES];

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      qs[i] = sneg[Q-1][i] ? -$signed({1'b0, cquo[Q][i]}) : $signed({1'b0, cquo[Q][i]});
      sum[i] = SW'(qs[i]);
    end
    sum[LANE_CX] = SW'(qs[LANE_CX]) + SW'(scx[Q-1]);
    sum[LANE_CY] = SW'(qs[LANE_CY]) + SW'(scy[Q-1]);
    for (int i = 0; i < NUM_LANES; i++) begin
      if (szero[Q-1]) begin
        res[i] = '0;
      end else if (sovf[Q-1][i]) begin
        res[i] = sneg[Q-1][i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else if (sum[i][SW-1:W-1] != {(SW-W+1){sum[i][SW-1]}}) begin
        res[i] = sum[i][SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        res[i] = sum[i][W-1:0];
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[Q];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    intersects <= !szero[Q-1];
    cross_x    <= res[LANE_CX];
    cross_y    <= res[LANE_CY];
    param_one  <= res[LANE_P1];
    param_two  <= res[LANE_P2];
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(Q+9) done)
    else $error("result strobe missing after fixed latency");

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !intersects) |-> (cross_x == '0 && cross_y == '0 &&
                               param_one == '0 && param_two == '0))
    else $error("parallel result carries nonzero fields");

  a_strobe_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cv[Q]))
    else $error("result strobe without a finished item");
`endif

endmodule
`default_nettype wire

// ===== tb/line_line_intersection_checker.sv =====
`default_nettype none
module line_line_intersection_checker #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire logic signed [COORD_BITS-1:0] line1_start_x,
  input  wire logic signed [COORD_BITS-1:0] line1_start_y,
  input  wire logic signed [COORD_BITS-1:0] line1_end_x,
  input  wire logic signed [COORD_BITS-1:0] line1_end_y,
  input  wire logic signed [COORD_BITS-1:0] line2_start_x,
  input  wire logic signed [COORD_BITS-1:0] line2_start_y,
  input  wire logic signed [COORD_BITS-1:0] line2_end_x,
  input  wire logic signed [COORD_BITS-1:0] line2_end_y,
  input  wire logic                         done,
  input  wire logic                         intersects,
  input  wire logic signed [COORD_BITS-1:0] cross_x,
  input  wire logic signed [COORD_BITS-1:0] cross_y,
  input  wire logic signed [COORD_BITS-1:0] param_one,
  input  wire logic signed [COORD_BITS-1:0] param_two,
  output int                                fail_count,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   hit;
    coord_t cx;
    coord_t cy;
    coord_t p1;
    coord_t p2;
  } crossing_t;

  crossing_t crossing_q[$];

  // clamp a wide value into the signed coordinate range
  function automatic coord_t clamp_coord(wide_t v);
    wide_t hi_lim;
    wide_t lo_lim;
    hi_lim = (wide_t'(1) <<< (COORD_BITS - 1)) - 1;
    lo_lim = -(wide_t'(1) <<< (COORD_BITS - 1));
    if (v > hi_lim) return coord_t'(hi_lim);
    if (v < lo_lim) return coord_t'(lo_lim);
    return coord_t'(v);
  endfunction

  // cramer's rule with exact wide arithmetic, divisions truncate toward zero
  function automatic crossing_t solve_crossing(coord_t ax, coord_t ay, coord_t bx,
                                               coord_t by, coord_t cx, coord_t cy,
                                               coord_t ex, coord_t ey);
    crossing_t r;
    wide_t d1x, d1y, d2x, d2y, sx, sy, den, n1, n2;
    d1x = wide_t'(ax) - wide_t'(bx);
    d1y = wide_t'(ay) - wide_t'(by);
    d2x = wide_t'(cx) - wide_t'(ex);
    d2y = wide_t'(cy) - wide_t'(ey);
    sx  = wide_t'(ax) - wide_t'(cx);
    sy  = wide_t'(ay) - wide_t'(cy);
    den = d1x * d2y - d1y * d2x;
    r = '0;
    if (den != 0) begin
      n1 = sx * d2y - sy * d2x;
      n2 = -(d1x * sy - d1y * sx);
      r.hit = 1'b1;
      r.cx = clamp_coord(wide_t'(cx) + (n2 * -d2x) / den);
      r.cy = clamp_coord(wide_t'(cy) + (n2 * -d2y) / den);
      r.p1 = clamp_coord((n1 <<< FRAC_BITS) / den);
      r.p2 = clamp_coord((n2 <<< FRAC_BITS) / den);
    end
    return r;
  endfunction

  assign pending = crossing_q.size();

  // predict on each input transfer, compare on each strobe
  always @(posedge clk) begin
    crossing_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy)
        crossing_q.push_back(solve_crossing(line1_start_x, line1_start_y, line1_end_x,
                                            line1_end_y, line2_start_x, line2_start_y,
                                            line2_end_x, line2_end_y));
      if (done) begin
        if (crossing_q.size() == 0) begin
          $error("result with no transfer waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = crossing_q.pop_front();
          if (intersects !== want.hit || cross_x !== want.cx || cross_y !== want.cy ||
              param_one !== want.p1 || param_two !== want.p2) begin
            fail_count <= fail_count + 1;
            if (intersects !== want.hit)
              $error("intersects: expected %0d actual %0d", want.hit, intersects);
            if (cross_x !== want.cx)
              $error("cross_x: expected %0d actual %0d", want.cx, cross_x);
            if (cross_y !== want.cy)
              $error("cross_y: expected %0d actual %0d", want.cy, cross_y);
            if (param_one !== want.p1)
              $error("param_one: expected %0d actual %0d", want.p1, param_one);
            if (param_two !== want.p2)
              $error("param_two: expected %0d actual %0d", want.p2, param_two);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/line_line_intersection_core_tb.sv =====
`default_nettype none
module line_line_intersection_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 32;
  localparam int LATENCY = CB + 10;
  localparam int RANDOM_ITEMS = 1450;

  typedef logic signed [CB-1:0] coord_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  coord_t l1sx = '0, l1sy = '0, l1ex = '0, l1ey = '0;
  coord_t l2sx = '0, l2sy = '0, l2ex = '0, l2ey = '0;
  logic done, intersects;
  coord_t cross_x, cross_y, param_one, param_two;
  int fail_count, pending;

  line_line_intersection_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .line1_start_x(l1sx), .line1_start_y(l1sy), .line1_end_x(l1ex), .line1_end_y(l1ey),
    .line2_start_x(l2sx), .line2_start_y(l2sy), .line2_end_x(l2ex), .line2_end_y(l2ey),
    .done(done), .intersects(intersects), .cross_x(cross_x), .cross_y(cross_y),
    .param_one(param_one), .param_two(param_two)
  );

  line_line_intersection_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .line1_start_x(l1sx), .line1_start_y(l1sy), .line1_end_x(l1ex), .line1_end_y(l1ey),
    .line2_start_x(l2sx), .line2_start_y(l2sy), .line2_end_x(l2ex), .line2_end_y(l2ey),
    .done(done), .intersects(intersects), .cross_x(cross_x), .cross_y(cross_y),
    .param_one(param_one), .param_two(param_two),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("line_line_intersection_core_tb: errors");
    $finish;
  end

  // random coordinate: full range, extremes, or small values
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return coord_t'({1'b0, {(CB-1){1'b1}}});
      1: return coord_t'({1'b1, {(CB-1){1'b0}}});
      2, 3, 4: return coord_t'($urandom);
      default: return coord_t'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
    endcase
  endfunction

  // one transfer; idle gap first when allowed
  task automatic send_lines(coord_t a, coord_t b, coord_t c, coord_t d,
                            coord_t e, coord_t f, coord_t g, coord_t h, bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    l1sx <= a; l1sy <= b; l1ex <= c; l1ey <= d;
    l2sx <= e; l2sy <= f; l2ex <= g; l2ey <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    coord_t mx, mn, one, a, b, c, d, e, f, g, h;
    int kind;
    mx = coord_t'({1'b0, {(CB-1){1'b1}}});
    mn = coord_t'({1'b1, {(CB-1){1'b0}}});
    one = 32'sh0001_0000;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: crossing axes, parallel, degenerate, extremes, saturation
    send_lines(-one, 0, one, 0, 0, -one, 0, one, 0);
    send_lines(0, 0, one, one, 0, one, one, 2*one, 0);
    send_lines(0, 0, one, one, one, one, 2*one, 2*one, 0);
    send_lines(0, 0, 0, 0, one, 0, 0, one, 0);
    send_lines(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_lines(mx, mx, mn, mn, mn, mx, mx, mn, 0);
    send_lines(mn, mn, mn, mx, mx, mn, mx, mx, 0);
    send_lines(mx, mn, mx, mn, mn, mx, mx, mn, 0);
    send_lines(0, 0, 1, 0, mx, mn, mx, mx, 0);
    send_lines(0, 0, 1, 1, mn, mx, mn, mx - 1, 0);
    send_lines(mx, 0, mn, 1, 0, mx, 1, mn, 0);
    send_lines(-1, -1, 1, 2, 3, -5, -7, 11, 0);
    send_lines(mn, mn, mx, mx, mn, mx, mx, mn, 0);
    send_lines(0, 0, 2, 1, 0, 1, 2, 2, 0);
    send_lines(-1, -1, -1, -1, -1, -1, -1, -1, 0);

    // hold off until the pipeline drains
    start <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      a = pick_coord(); b = pick_coord(); c = pick_coord(); d = pick_coord();
      e = pick_coord(); f = pick_coord(); g = pick_coord(); h = pick_coord();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // parallel: line two is line one shifted
        g = e + (c - a); h = f + (d - b);
      end else if (kind == 1) begin
        // point-like line one: start equals end
        c = a; d = b;
      end
      send_lines(a, b, c, d, e, f, g, h, !(i >= 400 && i < 700));
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("line_line_intersection_core_tb: clean");
    end else begin
      $display("line_line_intersection_core_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/lli_pkg.sv
design/lli_cell.sv
design/line_line_intersection_core.sv
tb/line_line_intersection_checker.sv
tb/line_line_intersection_core_tb.sv
